// ----- hdl/gmps_pkg.sv -----
package gmps_pkg;

  localparam logic [15:0] GAP_THRESHOLD_RST = 16'd3000;
  localparam logic [6:0]  CREEP_END_RST     = 7'd25;
  localparam logic [6:0]  REVERSE_END_RST   = 7'd110;
  localparam logic [6:0]  PAUSE_END_RST     = 7'd120;

  localparam logic signed [1:0] SPEED_FWD  = 2'sb01;
  localparam logic signed [1:0] SPEED_STOP = 2'sb00;
  localparam logic signed [1:0] SPEED_REV  = 2'sb11;
  localparam logic [4:0] STEER_STRAIGHT = 5'd0;
  localparam logic [4:0] STEER_RIGHT    = 5'd25;

  typedef enum logic [1:0] {
    CFG_GAP_THRESHOLD = 2'd0,
    CFG_CREEP_END     = 2'd1,
    CFG_REVERSE_END   = 2'd2,
    CFG_PAUSE_END     = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MP_FIRST  = 2'd0,
    MP_TRACK  = 2'd1,
    MP_IN_GAP = 2'd2
  } meas_phase_t;

  typedef struct packed {
    logic signed [15:0] rear_side_distance;
    logic signed [15:0] front_ultrasonic_distance;
    logic [31:0]        odometer_mm;
  } in_item_t;

  typedef struct packed {
    logic signed [1:0] speed_cmd;
    logic [4:0]        steer_cmd;
    logic              gap_valid;
    logic [31:0]       gap_length;
    logic              park_done;
  } out_item_t;

endpackage

// ----- hdl/gap_measure_park_sequencer.sv -----
// Channel  Direction  Handshake           Payload
// in_      input      in_valid/in_ready   gmps_pkg::in_item_t
// out_     output     out_valid/out_ready gmps_pkg::out_item_t
// cfg_     input      cfg_we              cfg_index, cfg_data
//
// One item per cycle while in_ready is high; each result is registered in the
// output or skid register. The step is one compare chain and a 32-bit subtract.
// A two-entry output buffer (output register plus skid register) lets an item
// be taken while a result waits; in_ready drops only when both are full.
// rst_n is synchronous and active low; it restores the register defaults.
module gap_measure_park_sequencer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  gmps_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output gmps_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import gmps_pkg::*;

  logic [15:0] gap_threshold_r;
  logic [6:0]  creep_end_r, reverse_end_r, pause_end_r;

  meas_phase_t        meas_phase_r, meas_phase_nxt;
  logic signed [15:0] prev_dist_r;
  logic [31:0]        gap_start_r, gap_start_nxt;
  logic [6:0]         move_count_r, move_count_nxt;
  logic               finished_r, finished_nxt;

  out_item_t out_q_r, skid_q_r;
  logic      out_valid_r, skid_valid_r;

  logic      push, pop;
  out_item_t res;

  // Sequencer chain signals.
  logic [6:0]        c1, c2, c3;
  logic signed [1:0] seq_speed;
  logic [4:0]        seq_steer;
  logic              done_now;
  logic [31:0]       glen;
  logic              gap_end;

  assign push      = in_valid && in_ready;
  assign pop       = out_valid_r && out_ready;
  assign in_ready  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_threshold_r <= GAP_THRESHOLD_RST;
      creep_end_r     <= CREEP_END_RST;
      reverse_end_r   <= REVERSE_END_RST;
      pause_end_r     <= PAUSE_END_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_GAP_THRESHOLD: gap_threshold_r <= cfg_data;
        CFG_CREEP_END:     creep_end_r     <= cfg_data[6:0];
        CFG_REVERSE_END:   reverse_end_r   <= cfg_data[6:0];
        CFG_PAUSE_END:     pause_end_r     <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Each phase test sees the counter left by the one before it, so a
  // boundary reached in one phase lets the next phase run on the same item.
  always_comb begin
    seq_speed = SPEED_FWD;
    seq_steer = STEER_STRAIGHT;
    c1 = move_count_r;
    if (move_count_r >= 7'd1 && move_count_r < creep_end_r) begin
      c1 = move_count_r + 7'd1;
    end
    c2 = c1;
    if (c1 >= creep_end_r && c1 < reverse_end_r) begin
      seq_speed = SPEED_REV;
      seq_steer = STEER_RIGHT;
      c2 = c1 + 7'd1;
    end
    c3 = c2;
    if (c2 >= reverse_end_r && c2 < pause_end_r) begin
      seq_speed = SPEED_STOP;
      seq_steer = STEER_STRAIGHT;
      c3 = c2 + 7'd1;
    end
    done_now = 1'b0;
    if (c3 >= pause_end_r) begin
      if (in_data.front_ultrasonic_distance < 0) begin
        seq_speed = SPEED_REV;
        seq_steer = STEER_STRAIGHT;
      end else begin
        done_now = 1'b1;
      end
    end
  end

  assign glen    = in_data.odometer_mm - gap_start_r;
  assign gap_end = (meas_phase_r == MP_IN_GAP) && (prev_dist_r < 0) &&
                   (in_data.rear_side_distance > 0);

  // Detector next state; it does not run on the done item or after it.
  always_comb begin
    meas_phase_nxt = meas_phase_r;
    gap_start_nxt  = gap_start_r;
    move_count_nxt = move_count_r;
    finished_nxt   = finished_r;
    if (!finished_r) begin
      move_count_nxt = c3;
      if (done_now) begin
        finished_nxt = 1'b1;
      end else begin
        unique case (meas_phase_r)
          MP_TRACK: begin
            if (prev_dist_r > 0 && in_data.rear_side_distance < 0) begin
              meas_phase_nxt = MP_IN_GAP;
              gap_start_nxt  = in_data.odometer_mm;
            end
          end
          MP_IN_GAP: begin
            if (gap_end) begin
              meas_phase_nxt = MP_TRACK;
              if (c3 == 7'd0 && glen > {16'd0, gap_threshold_r}) begin
                move_count_nxt = 7'd1;
              end
            end
          end
          default: meas_phase_nxt = MP_TRACK;
        endcase
      end
    end
  end

  // Result of the item being accepted.
  always_comb begin
    res.speed_cmd  = SPEED_STOP;
    res.steer_cmd  = STEER_STRAIGHT;
    res.gap_valid  = 1'b0;
    res.gap_length = 32'd0;
    res.park_done  = 1'b1;
    if (!finished_r && !done_now) begin
      res.speed_cmd = seq_speed;
      res.steer_cmd = seq_steer;
      res.park_done = 1'b0;
      if (gap_end) begin
        res.gap_valid  = 1'b1;
        res.gap_length = glen;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meas_phase_r <= MP_FIRST;
      prev_dist_r  <= 16'sd0;
      gap_start_r  <= 32'd0;
      move_count_r <= 7'd0;
      finished_r   <= 1'b0;
    end else if (push) begin
      meas_phase_r <= meas_phase_nxt;
      gap_start_r  <= gap_start_nxt;
      move_count_r <= move_count_nxt;
      finished_r   <= finished_nxt;
      if (!finished_r && !done_now) begin
        prev_dist_r <= in_data.rear_side_distance;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop) begin
      if (skid_valid_r) begin
        out_q_r      <= skid_q_r;
        skid_valid_r <= push;
        if (push) begin
          skid_q_r <= res;
        end
      end else begin
        out_valid_r <= push;
        if (push) begin
          out_q_r <= res;
        end
      end
    end else if (push) begin
      if (!out_valid_r) begin
        out_q_r     <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_q_r     <= res;
        skid_valid_r <= 1'b1;
      end
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds an item while the output register is empty");

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |=> finished_r)
    else $error("park done flag cleared without reset");

  a_frozen_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    (push && finished_r) |=> ($stable(meas_phase_r) && $stable(move_count_r) &&
                              $stable(gap_start_r)))
    else $error("state changed on an item after parking finished");

endmodule
